FILE: src/wtf_pkg.sv
// ----------------------------------------------------------------------------
// wtf_pkg: shared types and tables of the word token filter
// Word tables, descriptor layout and control structs used by front and back.
// ----------------------------------------------------------------------------
`default_nettype none

package wtf_pkg;

	// fixed-width word tables, right-justified, zero-padded
	localparam int STR_W = 10;
	typedef logic [8*STR_W-1:0] str_t;

	localparam int NORM_N = 36;
	localparam int STOP_N = 23;
	localparam int RESULT_LIMIT = 32;
	localparam int DESC_DEPTH = 4;
	localparam int DESC_AW = 2;
	localparam int LEN_W = 7;
	localparam int ID_W = 6;
	localparam logic [7:0] STRIP_CHAR = 8'h73;

	// configuration register indexes
	localparam logic CFG_MIN_KEEP = 1'b0;
	localparam logic CFG_PLURAL_STRIP = 1'b1;

	localparam str_t NORM_FROM [NORM_N] = '{
		"dogs", "puppy", "puppies", "men", "women", "boys", "girls", "children",
		"kids", "kid", "boy", "girl", "running", "runs", "ran", "playing",
		"plays", "played", "jumping", "jumps", "jumped", "leaping", "leaps",
		"climbing", "climbs", "walking", "walks", "standing", "stands",
		"sitting", "sits", "bicycle", "bicycles", "motorcycle", "football",
		"soccer"
	};

	localparam str_t NORM_TO [NORM_N] = '{
		"dog", "dog", "dog", "man", "woman", "boy", "girl", "child",
		"child", "child", "child", "child", "run", "run", "run", "play",
		"play", "play", "jump", "jump", "jump", "jump", "jump",
		"climb", "climb", "walk", "walk", "stand", "stand",
		"sit", "sit", "bike", "bike", "bike", "ball",
		"ball"
	};

	localparam str_t STOP_WORDS [STOP_N] = '{
		"a", "an", "the", "is", "are", "was", "were", "in", "on", "at", "of",
		"to", "with", "and", "or", "by", "for", "into", "from", "near", "next",
		"front", "while"
	};

	typedef struct packed {
		logic [5:0] min_keep;
		logic [5:0] plural_strip;
	} cfg_t;

	// one finished word as the back end replays it
	typedef struct packed {
		logic [LEN_W-1:0] src_len;
		logic [5:0]       out_len;
		logic             rep;
		logic [ID_W-1:0]  rep_id;
		logic             trunc;
	} desc_t;

	typedef struct packed {
		logic       char_we;
		logic [6:0] ch;
		logic       desc_we;
		desc_t      desc;
	} front_push_t;

	typedef struct packed {
		logic char_full;
		logic desc_full;
	} back_status_t;

	// number of characters in a table word
	function automatic logic [3:0] str_len(input str_t s);
		logic [3:0] n;
		n = 4'd0;
		for (int b = 0; b < STR_W; b++) begin
			if (s[8*b +: 8] != 8'h00) n = n + 4'd1;
		end
		return n;
	endfunction

	// character at position pos of a table word of length len
	function automatic logic [7:0] char_at(input str_t s, input logic [3:0] len,
			input logic [LEN_W-1:0] pos);
		logic [7:0] r;
		r = 8'h00;
		for (int b = 0; b < STR_W; b++) begin
			if ({3'b000, len} == pos + 7'd1 + 7'(b)) r = s[8*b +: 8];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/wtf_char_if.sv
// ----------------------------------------------------------------------------
// wtf_char_if: text byte channel
// Valid/ready channel carrying one raw text byte and its end-of-text flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface wtf_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_text;

	modport source(output valid, char_in, end_of_text, input ready);
	modport sink(input valid, char_in, end_of_text, output ready);
endinterface

`default_nettype wire

FILE: src/wtf_word_if.sv
// ----------------------------------------------------------------------------
// wtf_word_if: emitted word character channel
// Valid/ready channel carrying one character of a kept word and its flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface wtf_word_if;
	logic       valid;
	logic       ready;
	logic [6:0] word_char;
	logic       word_end;
	logic       word_truncated;

	modport source(output valid, word_char, word_end, word_truncated, input ready);
	modport sink(input valid, word_char, word_end, word_truncated, output ready);
endinterface

`default_nettype wire

FILE: src/wtf_ram.sv
// ----------------------------------------------------------------------------
// wtf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
`default_nettype none

module wtf_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
	end

	// registered read
	always_ff @(posedge clk) begin
		if (re) rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: src/wtf_front.sv
// ----------------------------------------------------------------------------
// wtf_front: character intake and word classification
// Lowercases and stores word characters, matches them against the word tables
// as they arrive, and queues a descriptor for each finished word.
// ----------------------------------------------------------------------------
`default_nettype none

module wtf_front #(
	parameter int MAX_WORD = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	wtf_char_if.sink                   text_in,
	input  wire wtf_pkg::cfg_t         cfg,
	input  wire wtf_pkg::back_status_t status,
	output wtf_pkg::front_push_t       push
);

	localparam int LW = wtf_pkg::LEN_W;

	logic [LW-1:0]               cnt_q;
	logic                        ovf_q;
	logic [7:0]                  last_q;
	logic [wtf_pkg::NORM_N-1:0]  nm_q;
	logic [wtf_pkg::STOP_N-1:0]  sm_q;
	logic [wtf_pkg::STOP_N-1:0]  sp_q;

	logic                        acc, digit, upper, lower, alnum;
	logic [7:0]                  lc;
	logic                        keep_char, ovf_now, finish;
	logic [LW-1:0]               cnt_new;
	logic [7:0]                  last_new;
	logic [wtf_pkg::NORM_N-1:0]  nm_new, nexact;
	logic [wtf_pkg::STOP_N-1:0]  sm_new, sexact, sp_new;
	logic                        rep, strip, stop, keep;
	logic [wtf_pkg::ID_W-1:0]    rep_id;
	logic [3:0]                  to_len, elen;
	logic [LW-1:0]               n;
	logic [5:0]                  out_len;

	assign text_in.ready = !status.char_full && !status.desc_full;
	assign acc = text_in.valid && text_in.ready;

	// character class and lowercase
	always_comb begin
		digit = text_in.char_in >= 8'h30 && text_in.char_in <= 8'h39;
		upper = text_in.char_in >= 8'h41 && text_in.char_in <= 8'h5a;
		lower = text_in.char_in >= 8'h61 && text_in.char_in <= 8'h7a;
		alnum = digit || upper || lower;
		lc = upper ? text_in.char_in + 8'h20 : text_in.char_in;
	end

	assign keep_char = acc && alnum && (cnt_q < LW'(MAX_WORD));
	assign ovf_now = acc && alnum && !keep_char;
	assign finish = acc && (!alnum || text_in.end_of_text);
	assign cnt_new = cnt_q + LW'(keep_char);
	assign last_new = keep_char ? lc : last_q;

	// running prefix match against every table word
	always_comb begin
		for (int e = 0; e < wtf_pkg::NORM_N; e++) begin
			elen = wtf_pkg::str_len(wtf_pkg::NORM_FROM[e]);
			nm_new[e] = keep_char ?
				(nm_q[e] && cnt_q < LW'(elen) &&
				 wtf_pkg::char_at(wtf_pkg::NORM_FROM[e], elen, cnt_q) == lc) : nm_q[e];
			nexact[e] = nm_new[e] && cnt_new == LW'(elen);
		end
		for (int e = 0; e < wtf_pkg::STOP_N; e++) begin
			elen = wtf_pkg::str_len(wtf_pkg::STOP_WORDS[e]);
			sm_new[e] = keep_char ?
				(sm_q[e] && cnt_q < LW'(elen) &&
				 wtf_pkg::char_at(wtf_pkg::STOP_WORDS[e], elen, cnt_q) == lc) : sm_q[e];
			sexact[e] = sm_new[e] && cnt_new == LW'(elen);
			sp_new[e] = keep_char ? (sm_q[e] && cnt_q == LW'(elen)) : sp_q[e];
		end
	end

	// first normalization entry that matches
	always_comb begin
		rep_id = '0;
		for (int e = wtf_pkg::NORM_N - 1; e >= 0; e--) begin
			if (nexact[e]) rep_id = wtf_pkg::ID_W'(e);
		end
		rep = |nexact;
		to_len = wtf_pkg::str_len(wtf_pkg::NORM_TO[rep_id]);
	end

	// normalized length and keep decision
	always_comb begin
		strip = !rep && cnt_new > {1'b0, cfg.plural_strip} && last_new == wtf_pkg::STRIP_CHAR;
		if (rep) n = LW'(to_len);
		else if (strip) n = cnt_new - LW'(1);
		else n = cnt_new;
		if (rep) stop = 1'b0;
		else if (strip) stop = |sp_new;
		else stop = |sexact;
		keep = n >= {1'b0, cfg.min_keep} && n != '0 && !stop;
		if (!keep) out_len = '0;
		else if (n > LW'(wtf_pkg::RESULT_LIMIT)) out_len = 6'(wtf_pkg::RESULT_LIMIT);
		else out_len = n[5:0];
	end

	// push toward the back end
	always_comb begin
		push.char_we = keep_char;
		push.ch = lc[6:0];
		push.desc_we = finish && cnt_new != '0;
		push.desc.src_len = cnt_new;
		push.desc.out_len = out_len;
		push.desc.rep = rep;
		push.desc.rep_id = rep_id;
		push.desc.trunc = ovf_q || ovf_now;
	end

	// pending word state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			nm_q <= '1;
			sm_q <= '1;
			sp_q <= '0;
			last_q <= '0;
		end else if (finish) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			nm_q <= '1;
			sm_q <= '1;
		end else begin
			cnt_q <= cnt_new;
			ovf_q <= ovf_q || ovf_now;
			nm_q <= nm_new;
			sm_q <= sm_new;
			sp_q <= sp_new;
			last_q <= last_new;
		end
	end

endmodule

`default_nettype wire

FILE: src/wtf_back.sv
// ----------------------------------------------------------------------------
// wtf_back: word replay and emission
// Holds the character queue and the word descriptor queue, replays each word
// one step a cycle unless the output stalls, and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wtf_back #(
	parameter int CHAR_DEPTH = 128
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire wtf_pkg::front_push_t push,
	output wtf_pkg::back_status_t     status,
	wtf_word_if.source                word_out
);

	localparam int AW = $clog2(CHAR_DEPTH);
	localparam int LW = wtf_pkg::LEN_W;

	logic [AW-1:0]            wr_ptr_q, rd_ptr_q;
	logic [AW:0]              occ_q;
	wtf_pkg::desc_t           dq_q [wtf_pkg::DESC_DEPTH];
	logic [wtf_pkg::DESC_AW-1:0] dwp_q, drp_q;
	logic [wtf_pkg::DESC_AW:0]   dcnt_q;
	logic [LW-1:0]            k_q;

	logic                     s1_v_q, s1_emit_s1, s1_end_s1, s1_trunc_s1, s1_rep_s1;
	logic [6:0]               s1_rch_s1;
	logic                     out_v_q, out_end_q, out_trunc_q;
	logic [6:0]               out_char_q;

	wtf_pkg::desc_t           head;
	logic [LW-1:0]            steps, out_len_w;
	logic [3:0]               to_len;
	logic [7:0]               rep_ch;
	logic                     out_free, s1_move, issue, pop, emit, last_step, desc_pop;
	logic [6:0]               ram_rd;

	assign status.char_full = occ_q == (AW + 1)'(CHAR_DEPTH);
	assign status.desc_full = dcnt_q == (wtf_pkg::DESC_AW + 1)'(wtf_pkg::DESC_DEPTH);

	// replay step of the head word
	always_comb begin
		head = dq_q[drp_q];
		out_len_w = {1'b0, head.out_len};
		steps = (head.src_len > out_len_w) ? head.src_len : out_len_w;
		out_free = !out_v_q || word_out.ready;
		s1_move = s1_v_q && (!s1_emit_s1 || out_free);
		issue = dcnt_q != '0 && (!s1_v_q || s1_move);
		pop = issue && k_q < head.src_len;
		emit = k_q < out_len_w;
		last_step = k_q == steps - LW'(1);
		desc_pop = issue && last_step;
		to_len = wtf_pkg::str_len(wtf_pkg::NORM_TO[head.rep_id]);
		rep_ch = wtf_pkg::char_at(wtf_pkg::NORM_TO[head.rep_id], to_len, k_q);
	end

	wtf_ram #(.WIDTH(7), .DEPTH(CHAR_DEPTH)) u_char_ram (
		.clk   (clk),
		.we    (push.char_we),
		.waddr (wr_ptr_q),
		.wdata (push.ch),
		.re    (pop),
		.raddr (rd_ptr_q),
		.rdata (ram_rd)
	);

	// character queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q <= '0;
		end else begin
			if (push.char_we)
				wr_ptr_q <= (wr_ptr_q == AW'(CHAR_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(CHAR_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			occ_q <= occ_q + (AW + 1)'(push.char_we) - (AW + 1)'(pop);
		end
	end

	// descriptor queue payload
	always_ff @(posedge clk) begin
		if (push.desc_we) dq_q[dwp_q] <= push.desc;
	end

	// descriptor queue control and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwp_q <= '0;
			drp_q <= '0;
			dcnt_q <= '0;
			k_q <= '0;
		end else begin
			if (push.desc_we) dwp_q <= dwp_q + wtf_pkg::DESC_AW'(1);
			if (desc_pop) drp_q <= drp_q + wtf_pkg::DESC_AW'(1);
			dcnt_q <= dcnt_q + (wtf_pkg::DESC_AW + 1)'(push.desc_we)
				- (wtf_pkg::DESC_AW + 1)'(desc_pop);
			if (issue) k_q <= last_step ? '0 : k_q + LW'(1);
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s1_v_q <= 1'b0;
		else if (issue) s1_v_q <= 1'b1;
		else if (s1_move) s1_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			s1_emit_s1 <= emit;
			s1_end_s1 <= k_q + LW'(1) == out_len_w;
			s1_trunc_s1 <= head.trunc;
			s1_rep_s1 <= head.rep;
			s1_rch_s1 <= rep_ch[6:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (s1_move && s1_emit_s1) out_v_q <= 1'b1;
		else if (word_out.ready) out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_move && s1_emit_s1) begin
			out_char_q <= s1_rep_s1 ? s1_rch_s1 : ram_rd;
			out_end_q <= s1_end_s1;
			out_trunc_q <= s1_trunc_s1;
		end
	end

	assign word_out.valid = out_v_q;
	assign word_out.word_char = out_char_q;
	assign word_out.word_end = out_end_q;
	assign word_out.word_truncated = out_trunc_q;

endmodule

`default_nettype wire

FILE: src/word_token_filter_normalizer.sv
// ----------------------------------------------------------------------------
// word_token_filter_normalizer: stop-word filtering tokenizer
// Splits a byte stream into words, normalizes and filters them, and emits the
// kept words one character per item.
// ----------------------------------------------------------------------------
// channel    dir  handshake     payload
// text_in    in   valid/ready   char_in[7:0], end_of_text
// word_out   out  valid/ready   word_char[6:0], word_end, word_truncated
// cfg        in   cfg_we        cfg_index[0], cfg_data[5:0]
//
// text_in takes one byte per cycle; it stalls only when the character queue
// (CHAR_DEPTH entries) or the word descriptor queue (4 words) is full.
// The back end replays a word in max(source length, emitted length) steps and
// reads one queued character per source character. With an idle back end, a
// word passes the descriptor queue, read stage and output register in order.
// No clearing pass after reset: reset clears the queues.
// word_out stalls hold the output register and fill the queues behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module word_token_filter_normalizer #(
	parameter int MAX_WORD = 32,
	parameter int CHAR_DEPTH = 128
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	wtf_char_if.sink        text_in,
	wtf_word_if.source      word_out,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [5:0] cfg_data
);

	wtf_pkg::cfg_t         cfg_q;
	wtf_pkg::front_push_t  push;
	wtf_pkg::back_status_t status;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_keep <= 6'd2;
			cfg_q.plural_strip <= 6'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wtf_pkg::CFG_MIN_KEEP:     cfg_q.min_keep <= cfg_data;
				wtf_pkg::CFG_PLURAL_STRIP: cfg_q.plural_strip <= cfg_data;
				default: ;
			endcase
		end
	end

	wtf_front #(.MAX_WORD(MAX_WORD)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.text_in (text_in),
		.cfg     (cfg_q),
		.status  (status),
		.push    (push)
	);

	wtf_back #(.CHAR_DEPTH(CHAR_DEPTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.status   (status),
		.word_out (word_out)
	);

endmodule

`default_nettype wire

FILE: src/wtf_checker.sv
// ----------------------------------------------------------------------------
// wtf_checker: port-level checks of the word token filter
// Watches the output channel over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wtf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [6:0] out_char,
	input wire logic       out_end,
	input wire logic       out_trunc
);

	// a stalled item stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	// a stalled item keeps its payload
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_char) && $stable(out_end) &&
		$stable(out_trunc))
		else $error("output payload changed while stalled");

	// only lowercase letters and digits leave the block
	a_char_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_char >= 7'h30 && out_char <= 7'h39) ||
		(out_char >= 7'h61 && out_char <= 7'h7a))
		else $error("emitted character outside word class");

	// nothing is offered right after reset
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind word_token_filter_normalizer wtf_checker u_wtf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (word_out.valid),
	.out_ready (word_out.ready),
	.out_char  (word_out.word_char),
	.out_end   (word_out.word_end),
	.out_trunc (word_out.word_truncated)
);

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench of the word token filter
// Random and directed text streams pass the filter; a predictor with its own
// word store and the package tables checks every emitted character in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

	localparam int MAX_WORD = 32;
	localparam int N_RANDOM = 340;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
	} text_item_t;

	typedef struct packed {
		logic [6:0] ch;
		logic       last;
		logic       trunc;
	} word_char_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [5:0] cfg_data;

	wtf_char_if text_in();
	wtf_word_if word_out();

	word_token_filter_normalizer #(.MAX_WORD(MAX_WORD)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.text_in(text_in.sink),
		.word_out(word_out.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	text_item_t text_queue[$];
	word_char_t expected_chars[$];
	int mismatches;
	int bytes_taken;
	int chars_seen;
	int idle_cycles;
	bit stall_enable;
	bit in_fire;

	// predictor state
	logic [7:0] pend_word[MAX_WORD];
	int pend_len;
	bit pend_over;
	logic [5:0] min_keep;
	logic [5:0] plural_strip;

	// table word as a plain string
	function automatic string table_word(input wtf_pkg::str_t s);
		string r;
		r = "";
		for (int b = wtf_pkg::STR_W - 1; b >= 0; b--) begin
			if (s[8*b +: 8] != 8'h00) r = {r, string'(s[8*b +: 8])};
		end
		return r;
	endfunction

	// finish the pending word and queue the characters that survive the filter
	task automatic close_word();
		string w;
		int n;
		bit replaced;
		bit stop;
		word_char_t e;
		logic [7:0] wc;
		replaced = 0;
		stop = 0;
		w = "";
		for (int i = 0; i < pend_len; i++) w = {w, string'(pend_word[i])};
		for (int i = 0; i < wtf_pkg::NORM_N; i++) begin
			if (!replaced && w == table_word(wtf_pkg::NORM_FROM[i])) begin
				w = table_word(wtf_pkg::NORM_TO[i]);
				replaced = 1;
			end
		end
		n = w.len();
		if (!replaced && n > plural_strip && n > 0 && w[n-1] == "s") begin
			n--;
			w = w.substr(0, n - 1);
		end
		for (int i = 0; i < wtf_pkg::STOP_N; i++)
			if (w == table_word(wtf_pkg::STOP_WORDS[i])) stop = 1;
		if (n >= min_keep && n > 0 && !stop) begin
			for (int i = 0; i < n && i < wtf_pkg::RESULT_LIMIT; i++) begin
				wc = w[i];
				e.ch = wc[6:0];
				e.last = (i + 1 == n || i + 1 == wtf_pkg::RESULT_LIMIT);
				e.trunc = pend_over;
				expected_chars = {expected_chars, e};
			end
		end
		pend_len = 0;
		pend_over = 0;
	endtask

	// one accepted text byte
	task automatic take_byte(input text_item_t t);
		logic [7:0] c;
		bit word_ch;
		c = t.ch;
		word_ch = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
		if (word_ch) begin
			if (c >= "A" && c <= "Z") c = c + 8'd32;
			if (pend_len < MAX_WORD) pend_word[pend_len++] = c;
			else pend_over = 1;
		end
		if (!word_ch || t.eot) begin
			if (pend_len > 0) close_word();
			pend_len = 0;
			pend_over = 0;
		end
	endtask

	task automatic report(input string what, input word_char_t got, input word_char_t want);
		mismatches++;
		$display("mismatch %s at char %0d: got %h/%b/%b want %h/%b/%b", what, chars_seen,
			got.ch, got.last, got.trunc, want.ch, want.last, want.trunc);
	endtask

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// input acceptance seen at the last rising edge
	always @(posedge clk) begin
		in_fire <= text_in.valid && text_in.ready;
	end

	// driver: present queued bytes with random idle bursts
	int send_gap;
	always @(negedge clk) begin
		if (!arst_n) begin
			text_in.valid <= 0;
			send_gap <= 0;
		end else if (text_in.valid && !in_fire) begin
			// hold item
		end else if (stall_enable && send_gap > 0) begin
			text_in.valid <= 0;
			send_gap <= send_gap - 1;
		end else if (stall_enable && $urandom_range(0, 9) == 0) begin
			text_in.valid <= 0;
			send_gap <= $urandom_range(0, 12);
		end else if (text_queue.size() > 0) begin
			text_item_t t;
			t = text_queue.pop_front();
			text_in.valid <= 1;
			text_in.char_in <= t.ch;
			text_in.end_of_text <= t.eot;
		end else begin
			text_in.valid <= 0;
		end
	end

	// receiver stalls in random bursts
	int recv_gap;
	always @(negedge clk) begin
		if (!arst_n) begin
			word_out.ready <= 0;
			recv_gap <= 0;
		end else if (stall_enable && recv_gap > 0) begin
			word_out.ready <= 0;
			recv_gap <= recv_gap - 1;
		end else if (stall_enable && $urandom_range(0, 9) == 0) begin
			word_out.ready <= 0;
			recv_gap <= $urandom_range(0, 12);
		end else begin
			word_out.ready <= 1;
		end
	end

	// monitor: predict on accepted bytes, check emitted characters
	always @(posedge clk) begin
		if (arst_n) begin
			if (text_in.valid && text_in.ready) begin
				text_item_t t;
				t.ch = text_in.char_in;
				t.eot = text_in.end_of_text;
				take_byte(t);
				bytes_taken++;
			end
			if (word_out.valid && word_out.ready) begin
				word_char_t got;
				word_char_t want;
				got.ch = word_out.word_char;
				got.last = word_out.word_end;
				got.trunc = word_out.word_truncated;
				if (expected_chars.size() == 0) begin
					report("unexpected", got, '0);
				end else begin
					want = expected_chars.pop_front();
					if (got.ch != want.ch) report("char", got, want);
					else if (got.last != want.last) report("end flag", got, want);
					else if (got.trunc != want.trunc) report("truncated flag", got, want);
				end
				chars_seen++;
			end
		end
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((text_in.valid && text_in.ready) || (word_out.valid && word_out.ready))
			idle_cycles <= 0;
		else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog expired, %0d chars outstanding", expected_chars.size());
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// append one byte to the pending stimulus
	task automatic queue_byte(input logic [7:0] ch, input bit eot);
		text_item_t t;
		t.ch = ch;
		t.eot = eot;
		text_queue = {text_queue, t};
	endtask

	task automatic push_text(input string s, input bit eot_last);
		for (int i = 0; i < s.len(); i++)
			queue_byte(s[i], (eot_last && i == s.len() - 1));
	endtask

	task automatic push_word(input string s);
		push_text(s, 0);
		queue_byte(8'h20, 1'b0);
	endtask

	// random word: mostly letters, sometimes table words, sometimes long
	task automatic push_random_word();
		string s;
		int n;
		int pick;
		logic [7:0] c;
		pick = $urandom_range(0, 9);
		if (pick < 3) s = table_word(wtf_pkg::NORM_FROM[$urandom_range(0, wtf_pkg::NORM_N - 1)]);
		else if (pick < 5)
			s = table_word(wtf_pkg::STOP_WORDS[$urandom_range(0, wtf_pkg::STOP_N - 1)]);
		else begin
			n = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 9);
			s = "";
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 5))
					0: c = 8'h30 + 8'($urandom_range(0, 9));
					1: c = 8'h41 + 8'($urandom_range(0, 25));
					2: c = "s";
					default: c = 8'h61 + 8'($urandom_range(0, 25));
				endcase
				s = {s, string'(c)};
			end
		end
		if ($urandom_range(0, 3) == 0) s[0] = s[0] & 8'hDF;
		push_text(s, 0);
		// separator: any non word byte, or end of text on the last char
		if ($urandom_range(0, 7) == 0) begin
			text_queue[$].eot = 1;
		end else begin
			do c = 8'($urandom_range(0, 255));
			while ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z"));
			queue_byte(c, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic wait_drained();
		while (text_queue.size() > 0 || text_in.valid || expected_chars.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_cfg(input logic idx, input logic [5:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == wtf_pkg::CFG_MIN_KEEP) min_keep = val;
		else plural_strip = val;
	endtask

	initial begin
		mismatches = 0;
		bytes_taken = 0;
		chars_seen = 0;
		idle_cycles = 0;
		stall_enable = 1;
		pend_len = 0;
		pend_over = 0;
		min_keep = 6'd2;
		plural_strip = 6'd3;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = wtf_pkg::CFG_MIN_KEEP;
		cfg_data = '0;
		text_in.valid = 0;
		text_in.char_in = '0;
		text_in.end_of_text = 0;
		word_out.ready = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: table words, stop words, plural rule, classes, overflow
		push_word("Dogs");
		push_word("puppies");
		push_word("CHILDREN");
		push_word("motorcycle");
		push_word("the");
		push_word("while");
		push_word("cats");
		push_word("bus");
		push_word("x");
		push_word("Az09");
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hFF, 1'b0);
		push_text("zy", 0);
		queue_byte(8'h7F, 1'b0);
		push_text("abcdefghijklmnopqrstuvwxyz0123456789ABCDEF", 1);
		push_text("end", 1);
		queue_byte(8'h00, 1'b1);
		wait_drained();

		// random phases across register settings, extremes included
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					write_cfg(wtf_pkg::CFG_MIN_KEEP, 6'd0);
					write_cfg(wtf_pkg::CFG_PLURAL_STRIP, 6'd0);
				end
				1: begin
					write_cfg(wtf_pkg::CFG_MIN_KEEP, 6'd63);
					write_cfg(wtf_pkg::CFG_PLURAL_STRIP, 6'd63);
				end
				2: begin
					write_cfg(wtf_pkg::CFG_MIN_KEEP, 6'd32);
					write_cfg(wtf_pkg::CFG_PLURAL_STRIP, 6'd32);
				end
				3: begin
					write_cfg(wtf_pkg::CFG_MIN_KEEP, 6'($urandom_range(1, 5)));
					write_cfg(wtf_pkg::CFG_PLURAL_STRIP, 6'($urandom_range(1, 6)));
				end
				default: begin
					write_cfg(wtf_pkg::CFG_MIN_KEEP, 6'd2);
					write_cfg(wtf_pkg::CFG_PLURAL_STRIP, 6'd3);
				end
			endcase
			// no idling in the final phase
			if (ph == 4) stall_enable = 0;
			while (text_queue.size() < N_RANDOM / 5) push_random_word();
			wait_drained();
		end

		$display("covered %0d text bytes and %0d emitted chars over five register settings",
			bytes_taken, chars_seen);
		if (mismatches == 0) $display("PASSED: all results match");
		else $display("FAILED: results differ");
		$finish;
	end

endmodule
